@@ rtl/wsd_pkg.sv @@
package wsd_pkg;

	// Field and register widths.
	localparam int BYTE_W    = 8;
	localparam int LIMIT_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int LEN_W     = 32;
	localparam int HDR_CNT_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_TOTAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_SELECT = 1'd1;

	// Reset value of the frame size limit.
	localparam logic [LIMIT_W-1:0] MAX_FRAME_RESET = 16'hFFFF;

	// A first byte of exactly this value marks a close frame.
	localparam logic [BYTE_W-1:0] CLOSE_BYTE = 8'h88;

	// Seven-bit length codes: the code for the 16-bit extended length and the largest short length.
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_MAX_SHORT = 7'd125;

	// Header byte counts at the end of the length byte, of the upper length half and of each extended length.
	localparam logic [HDR_CNT_W-1:0] HDR_EXT16_END = 4'd4;
	localparam logic [HDR_CNT_W-1:0] HDR_EXT64_LOW = 4'd6;
	localparam logic [HDR_CNT_W-1:0] HDR_EXT64_END = 4'd10;
	localparam logic [HDR_CNT_W-1:0] HDR_AFTER_LEN = 4'd2;

	// Event codes carried with each result word.
	typedef enum logic [1:0] {
		EV_DATA  = 2'd0,
		EV_EMPTY = 2'd1,
		EV_CLOSE = 2'd2,
		EV_ERROR = 2'd3
	} event_t;

	// One result word.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		event_t            ev;
		logic              last;
		logic              route;
	} res_t;

endpackage

@@ rtl/wsd_parser.sv @@
module wsd_parser
	import wsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic [LIMIT_W-1:0] max_frame_total,
	input  logic               protocol_select,
	output logic               res_valid,
	output res_t               res
);

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_LEN     = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_MASK    = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [BYTE_W-1:0]    first_q, first_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic                 len_hi_q, len_hi_d;
	logic [LIMIT_W-1:0]   remain_q, remain_d;
	logic [LEN_W-1:0]     key_q, key_d;
	logic [1:0]           idx_q, idx_d;
	logic                 halted_q, halted_d;

	logic [HDR_CNT_W-1:0] hdr_cnt_inc;
	logic [1:0]           idx_inc;
	logic [LIMIT_W:0]     total;
	logic                 too_big;
	logic [BYTE_W-1:0]    key_byte;
	logic [LIMIT_W-1:0]   remain_dec;
	logic                 is_close;

	// Shared arithmetic for the header and payload phases.
	assign hdr_cnt_inc = hdr_cnt_q + 4'd1;
	assign idx_inc     = idx_q + 2'd1;
	assign total       = {1'b0, len_q[LIMIT_W-1:0]} + {{(LIMIT_W+1-HDR_CNT_W){1'b0}}, hdr_cnt_inc};
	assign too_big     = len_hi_q || (len_q[LEN_W-1:LIMIT_W] != '0) ||
		(total >= {1'b0, max_frame_total});
	assign key_byte    = key_q[{idx_q, 3'b000} +: BYTE_W];
	assign remain_dec  = remain_q - 16'd1;
	assign is_close    = (first_q == CLOSE_BYTE);

	// Next state and the result for the byte being accepted.
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		first_d   = first_q;
		len_d     = len_q;
		len_hi_d  = len_hi_q;
		remain_d  = remain_q;
		key_d     = key_q;
		idx_d     = idx_q;
		halted_d  = halted_q;
		res_valid = 1'b0;
		res.data  = '0;
		res.ev    = EV_DATA;
		res.last  = 1'b0;
		res.route = protocol_select;
		if (accept && !halted_q) begin
			unique case (phase_q)
				PH_LEN: begin
					hdr_cnt_d = HDR_AFTER_LEN;
					len_hi_d  = 1'b0;
					key_d     = '0;
					idx_d     = '0;
					len_d     = '0;
					if (in_byte[6:0] <= LEN_CODE_MAX_SHORT) begin
						len_d   = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
						phase_d = PH_MASK;
					end else if (in_byte[6:0] == LEN_CODE_EXT16) begin
						phase_d = PH_EXT16;
					end else begin
						phase_d = PH_EXT64;
					end
				end
				PH_EXT16: begin
					len_d     = {16'd0, len_q[7:0], in_byte};
					hdr_cnt_d = hdr_cnt_inc;
					if (hdr_cnt_inc == HDR_EXT16_END) begin
						phase_d = PH_MASK;
					end
				end
				PH_EXT64: begin
					// The upper four length bytes only matter as nonzero or not.
					if (hdr_cnt_q < HDR_EXT64_LOW) begin
						if (in_byte != '0) begin
							len_hi_d = 1'b1;
						end
					end else begin
						len_d = {len_q[LEN_W-BYTE_W-1:0], in_byte};
					end
					hdr_cnt_d = hdr_cnt_inc;
					if (hdr_cnt_inc == HDR_EXT64_END) begin
						phase_d = PH_MASK;
					end
				end
				PH_MASK: begin
					key_d     = key_q | ({24'd0, in_byte} << {idx_q, 3'b000});
					idx_d     = idx_inc;
					hdr_cnt_d = hdr_cnt_inc;
					// All header checks are made on the last mask byte.
					if (idx_inc == 2'd0) begin
						if (too_big) begin
							halted_d  = 1'b1;
							res_valid = 1'b1;
							res.ev    = EV_ERROR;
						end else if (len_q == '0) begin
							phase_d   = PH_FIRST;
							res_valid = 1'b1;
							if (is_close) begin
								halted_d = 1'b1;
								res.ev   = EV_CLOSE;
							end else begin
								res.ev = EV_EMPTY;
							end
						end else begin
							remain_d = len_q[LIMIT_W-1:0];
							phase_d  = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					idx_d    = idx_inc;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						phase_d = PH_FIRST;
					end
					// Close frame payload is swallowed; the close event ends it.
					if (is_close) begin
						if (remain_dec == '0) begin
							halted_d  = 1'b1;
							res_valid = 1'b1;
							res.ev    = EV_CLOSE;
						end
					end else begin
						res_valid = 1'b1;
						res.data  = in_byte ^ key_byte;
						res.ev    = EV_DATA;
						res.last  = (remain_dec == '0);
					end
				end
				default: begin
					first_d = in_byte;
					phase_d = PH_LEN;
				end
			endcase
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			hdr_cnt_q <= '0;
			first_q   <= '0;
			len_q     <= '0;
			len_hi_q  <= 1'b0;
			remain_q  <= '0;
			key_q     <= '0;
			idx_q     <= '0;
			halted_q  <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			first_q   <= first_d;
			len_q     <= len_d;
			len_hi_q  <= len_hi_d;
			remain_q  <= remain_d;
			key_q     <= key_d;
			idx_q     <= idx_d;
			halted_q  <= halted_d;
		end
	end

endmodule

@@ rtl/wsd_out_buf.sv @@
module wsd_out_buf
	import wsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_res
);

	logic out_valid_q;
	res_t out_res_q;
	logic skid_valid_q;
	res_t skid_res_q;
	logic pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Output word register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_res_q    <= '0;
			skid_res_q   <= '0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_res_q    <= skid_res_q;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_res_q   <= push_res;
				out_valid_q <= 1'b1;
			end else begin
				skid_res_q   <= push_res;
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// WebSocket client frame deframer. Takes one stream byte per clock on the rx
// channel, walks the frame header (first byte, length code, optional 16-bit
// or 64-bit big-endian extended length, four mask bytes) and emits each
// unmasked payload byte on the ev channel through a registered output buffer,
// with last_of_frame set on the final byte. Empty frames, close frames and
// oversize frames give a single event word instead; after a close or a
// length error all further bytes are dropped until reset. The parser is a
// single registered step per byte, so a new byte can be accepted every
// clock; rx_stall rises only when the two-word output buffer is full
// because the consumer is holding ev_stall. Configuration writes are always
// ready and take effect on the next byte.
module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_stall,
	input  logic [BYTE_W-1:0]     in_byte,
	output logic                  ev_valid,
	input  logic                  ev_stall,
	output logic [BYTE_W-1:0]     out_byte,
	output logic [1:0]            event_res,
	output logic                  last_of_frame,
	output logic                  route,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LIMIT_W-1:0] max_frame_total_q;
	logic               protocol_select_q;
	logic               accept;
	logic               res_valid;
	res_t               res;
	logic               buf_full;
	res_t               out_res;

	assign cfg_ready = 1'b1;
	assign accept    = rx_valid && !buf_full;
	assign rx_stall  = buf_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_total_q <= MAX_FRAME_RESET;
			protocol_select_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_FRAME_TOTAL: max_frame_total_q <= cfg_data[LIMIT_W-1:0];
				CFG_PROTOCOL_SELECT: protocol_select_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	wsd_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_byte         (in_byte),
		.max_frame_total (max_frame_total_q),
		.protocol_select (protocol_select_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	wsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.full      (buf_full),
		.out_valid (ev_valid),
		.out_stall (ev_stall),
		.out_res   (out_res)
	);

	// Result word fields.
	assign out_byte      = out_res.data;
	assign event_res     = out_res.ev;
	assign last_of_frame = out_res.last;
	assign route         = out_res.route;

endmodule

@@ test/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 1ps

module tb_websocket_frame_deframer
	import wsd_pkg::*;
();

	// Parser position inside a frame, as the predictor tracks it.
	typedef enum logic [2:0] {
		PARSE_FIRST,
		PARSE_LEN,
		PARSE_EXT16,
		PARSE_EXT64,
		PARSE_MASK,
		PARSE_PAYLOAD
	} parse_phase_t;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_COUNT    = 8;
	localparam int PHASE_BYTES    = 100;
	localparam int REPORT_CAP     = 30;
	localparam int SETTLE_CYCLES  = 4;

	// Seven-bit length code that selects the 64-bit extended length.
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// Header forms of a generated frame.
	localparam int FORM_SHORT = 0;
	localparam int FORM_EXT16 = 1;
	localparam int FORM_EXT64 = 2;

	// Payload fill patterns.
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;
	localparam int FILL_ALT    = 3;

	// Ways the run ends; each one stops the block for good.
	localparam int END_SMALL_LIMIT = 0;
	localparam int END_CLOSE       = 1;
	localparam int END_HIGH_LENGTH = 2;
	localparam int END_AT_LIMIT    = 3;

	// First bytes used by the generator (FIN bit and opcode).
	localparam logic [7:0] FB_TEXT        = 8'h81;
	localparam logic [7:0] FB_BINARY      = 8'h82;
	localparam logic [7:0] FB_TEXT_NOFIN  = 8'h01;
	localparam logic [7:0] FB_CONT        = 8'h00;
	localparam logic [7:0] FB_CONT_FIN    = 8'h80;
	localparam logic [7:0] FB_PING        = 8'h89;
	localparam logic [7:0] FB_PONG        = 8'h8A;
	localparam logic [7:0] FB_CLOSE_NOFIN = 8'h08;

	// Predicts the event words of the deframer and checks the ones it emits.
	class frame_scoreboard;
		logic [LIMIT_W-1:0] limit;
		logic               sel;
		parse_phase_t       ph;
		logic [3:0]         hdr_cnt;
		logic [7:0]         first;
		logic [31:0]        len_acc;
		logic               high_nz;
		logic [15:0]        remaining;
		logic [31:0]        key;
		logic [1:0]         key_idx;
		logic               halted;
		res_t               pending_words[$];
		int                 errors;
		int                 bytes_in;
		int                 event_count[4];

		function new();
			limit = MAX_FRAME_RESET;
			sel = 1'b0;
			ph = PARSE_FIRST;
			hdr_cnt = '0;
			first = '0;
			len_acc = '0;
			high_nz = 1'b0;
			remaining = '0;
			key = '0;
			key_idx = '0;
			halted = 1'b0;
			errors = 0;
			bytes_in = 0;
			foreach (event_count[i])
				event_count[i] = 0;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= REPORT_CAP)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_MAX_FRAME_TOTAL)
				limit = data[LIMIT_W-1:0];
			else if (idx == CFG_PROTOCOL_SELECT)
				sel = data[0];
		endfunction

		function void push_word(logic [7:0] data, event_t ev, logic last);
			res_t w;
			w.data = data;
			w.ev = ev;
			w.last = last;
			w.route = sel;
			pending_words.push_back(w);
		endfunction

		// Advance the frame parser by one stream byte.
		function void note_byte(logic [7:0] b);
			logic [32:0] total;
			logic [7:0]  plain;
			bytes_in++;
			if (halted)
				return;
			case (ph)
				PARSE_LEN: begin
					hdr_cnt = 4'd2;
					high_nz = 1'b0;
					key = '0;
					key_idx = '0;
					len_acc = '0;
					if (b[6:0] <= LEN_CODE_MAX_SHORT) begin
						len_acc = {25'd0, b[6:0]};
						ph = PARSE_MASK;
					end else if (b[6:0] == LEN_CODE_EXT16)
						ph = PARSE_EXT16;
					else
						ph = PARSE_EXT64;
				end
				PARSE_EXT16: begin
					len_acc = {16'd0, len_acc[7:0], b};
					hdr_cnt = hdr_cnt + 4'd1;
					if (hdr_cnt == HDR_EXT16_END)
						ph = PARSE_MASK;
				end
				PARSE_EXT64: begin
					// The first four extended bytes are the upper half of the length.
					if (hdr_cnt < HDR_EXT64_LOW) begin
						if (b != 8'd0)
							high_nz = 1'b1;
					end else
						len_acc = {len_acc[23:0], b};
					hdr_cnt = hdr_cnt + 4'd1;
					if (hdr_cnt == HDR_EXT64_END)
						ph = PARSE_MASK;
				end
				PARSE_MASK: begin
					key[8*key_idx +: 8] = key[8*key_idx +: 8] | b;
					key_idx = key_idx + 2'd1;
					hdr_cnt = hdr_cnt + 4'd1;
					// The whole header is judged on the last mask byte.
					if (key_idx == 2'd0) begin
						total = {1'b0, len_acc} + {29'd0, hdr_cnt};
						if (high_nz || total >= {17'd0, limit}) begin
							halted = 1'b1;
							push_word(8'd0, EV_ERROR, 1'b0);
						end else if (len_acc == 32'd0) begin
							ph = PARSE_FIRST;
							if (first == CLOSE_BYTE) begin
								halted = 1'b1;
								push_word(8'd0, EV_CLOSE, 1'b0);
							end else
								push_word(8'd0, EV_EMPTY, 1'b0);
						end else begin
							remaining = len_acc[15:0];
							ph = PARSE_PAYLOAD;
						end
					end
				end
				PARSE_PAYLOAD: begin
					plain = b ^ key[8*key_idx +: 8];
					key_idx = key_idx + 2'd1;
					remaining = remaining - 16'd1;
					if (remaining == 16'd0)
						ph = PARSE_FIRST;
					// A close frame swallows its payload and reports once at the end.
					if (first == CLOSE_BYTE) begin
						if (remaining == 16'd0) begin
							halted = 1'b1;
							push_word(8'd0, EV_CLOSE, 1'b0);
						end
					end else
						push_word(plain, EV_DATA, remaining == 16'd0);
				end
				default: begin
					first = b;
					ph = PARSE_LEN;
				end
			endcase
		endfunction

		// Compare one emitted word against the oldest prediction.
		task check_word(logic [7:0] data, logic [1:0] ev, logic last, logic route);
			res_t w;
			if (pending_words.size() == 0) begin
				report($sformatf("word with nothing expected: data %02h event %0d", data, ev));
				return;
			end
			w = pending_words.pop_front();
			event_count[w.ev]++;
			if (data !== w.data)
				report($sformatf("out_byte %02h, expected %02h", data, w.data));
			if (ev !== w.ev)
				report($sformatf("event_res %0d, expected %0d", ev, w.ev));
			if (last !== w.last)
				report($sformatf("last_of_frame %0b, expected %0b", last, w.last));
			if (route !== w.route)
				report($sformatf("route %0b, expected %0b", route, w.route));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  rx_valid = 1'b0;
	logic                  rx_stall;
	logic [BYTE_W-1:0]     in_byte = '0;
	logic                  ev_valid;
	logic                  ev_stall = 1'b0;
	logic [BYTE_W-1:0]     out_byte;
	logic [1:0]            event_res;
	logic                  last_of_frame;
	logic                  route;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int                 idle_pct = 0;
	int                 stall_pct = 0;
	int                 idle_run = 0;
	int                 sent_bytes = 0;
	int                 cfg_writes = 0;
	logic [LIMIT_W-1:0] cur_limit = MAX_FRAME_RESET;
	frame_scoreboard    frames;

	websocket_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.in_byte       (in_byte),
		.ev_valid      (ev_valid),
		.ev_stall      (ev_stall),
		.out_byte      (out_byte),
		.event_res     (event_res),
		.last_of_frame (last_of_frame),
		.route         (route),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Consumer back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		ev_stall <= ($urandom_range(99) < stall_pct);
	end

	// Observe every handshake on the three channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				frames.write_reg(cfg_index, cfg_data);
			if (rx_valid && !rx_stall)
				frames.note_byte(in_byte);
			if (ev_valid && !ev_stall)
				frames.check_word(out_byte, event_res, last_of_frame, route);
		end
	end

	// End the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (ev_valid && !ev_stall) ||
				(cfg_valid && cfg_ready))
			idle_run <= 0;
		else if (idle_run == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL websocket_frame_deframer");
			$finish;
		end else
			idle_run <= idle_run + 1;
	end

	// Offer one stream byte after an optional gap and hold it until taken.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		rx_valid = 1'b1;
		in_byte = b;
		do @(posedge clk); while (rx_stall);
		@(negedge clk);
		rx_valid = 1'b0;
		sent_bytes++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_writes++;
		if (idx == CFG_MAX_FRAME_TOTAL)
			cur_limit = data[LIMIT_W-1:0];
	endtask

	// Wait until every predicted word is out and the parser has gone quiet.
	task automatic settle();
		while (frames.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Send one client frame. Declared lengths above 2000 send only six payload bytes.
	task automatic send_frame(input logic [7:0] fb, input int form, input logic [63:0] len,
			input logic mask_bit, input logic [31:0] mkey, input int fill);
		int         count;
		logic [7:0] b;
		send_byte(fb);
		case (form)
			FORM_EXT16: send_byte({mask_bit, LEN_CODE_EXT16});
			FORM_EXT64: send_byte({mask_bit, LEN_CODE_EXT64});
			default: send_byte({mask_bit, len[6:0]});
		endcase
		if (form == FORM_EXT16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end
		if (form == FORM_EXT64)
			for (int i = 7; i >= 0; i--)
				send_byte(len[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(mkey[8*i +: 8]);
		count = (len > 64'd2000) ? 6 : int'(len);
		for (int i = 0; i < count; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				FILL_ALT: b = i[0] ? 8'hFF : 8'h00;
				default: b = 8'($urandom);
			endcase
			send_byte(b);
		end
	endtask

	// A well-formed frame that fits under the current size limit and is never a close.
	task automatic random_frame();
		int          r;
		int          form;
		int          hsz;
		int          room;
		int          len;
		int          fill;
		logic [7:0]  fb;
		logic [31:0] mkey;
		r = $urandom_range(99);
		if (r < 55) begin
			form = FORM_SHORT;
			len = $urandom_range(20);
		end else if (r < 70) begin
			form = FORM_SHORT;
			len = $urandom_range(125, 21);
		end else if (r < 85) begin
			form = FORM_EXT16;
			len = $urandom_range(40);
		end else if (r < 93) begin
			form = FORM_EXT64;
			len = $urandom_range(30);
		end else begin
			form = FORM_EXT16;
			len = $urandom_range(400, 126);
		end
		hsz = (form == FORM_SHORT) ? 6 : (form == FORM_EXT16) ? 8 : 14;
		room = int'(cur_limit) - 1 - hsz;
		if (room < 0) begin
			form = FORM_SHORT;
			room = int'(cur_limit) - 7;
		end
		// Now and then land exactly one byte under the limit.
		if (len > room || (room <= 400 && $urandom_range(9) == 0))
			len = room;
		if (form == FORM_SHORT && len > 125)
			len = 125;

		case ($urandom_range(9))
			0: fb = FB_TEXT;
			1: fb = FB_BINARY;
			2: fb = FB_TEXT_NOFIN;
			3: fb = FB_CONT;
			4: fb = FB_PING;
			5: fb = FB_PONG;
			6: fb = FB_CLOSE_NOFIN;
			default: fb = 8'($urandom);
		endcase
		if (fb == CLOSE_BYTE)
			fb = FB_CONT_FIN;

		r = $urandom_range(9);
		mkey = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
		r = $urandom_range(19);
		fill = (r < 2) ? FILL_ZERO : (r < 4) ? FILL_ONES : (r == 4) ? FILL_ALT : FILL_RANDOM;
		send_frame(fb, form, 64'(len), 1'($urandom_range(1)), mkey, fill);
	endtask

	function automatic logic [LIMIT_W-1:0] phase_limit(input int p);
		case (p)
			1: return 16'd7;
			2: return 16'($urandom_range(300, 20));
			4: return 16'd14;
			5: return 16'($urandom_range(2000, 8));
			6: return 16'd135;
			7: return 16'($urandom_range(65535, 1000));
			default: return MAX_FRAME_RESET;
		endcase
	endfunction

	initial begin
		int    kind;
		int    phase_end;
		int    lim;
		string end_name[4];
		end_name[END_SMALL_LIMIT] = "limit below any header";
		end_name[END_CLOSE] = "close frame";
		end_name[END_HIGH_LENGTH] = "nonzero upper length";
		end_name[END_AT_LIMIT] = "frame exactly at the limit";
		frames = new();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames: each header form, all-ones and zero keys, mask bit clear,
		// non-text opcodes, an empty payload and a minimal payload.
		send_frame(FB_PING, FORM_SHORT, 64'd2, 1'b0, 32'hFFFF_FFFF, FILL_ALT);
		send_frame(FB_CLOSE_NOFIN, FORM_EXT16, 64'd0, 1'b1, 32'h0, FILL_RANDOM);
		send_frame(FB_CONT, FORM_EXT64, 64'd1, 1'b1, 32'h5AA5_C33C, FILL_ONES);

		// Random phases, each with its own limit, route and idle pattern.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle();
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 50; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 50; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			write_reg(CFG_MAX_FRAME_TOTAL, phase_limit(p));
			write_reg(CFG_PROTOCOL_SELECT, 16'(p % 2));
			phase_end = sent_bytes + PHASE_BYTES;
			while (sent_bytes < phase_end)
				random_frame();
		end

		// One terminating frame, then bytes that the stopped block must ignore.
		settle();
		idle_pct = 22;
		stall_pct = 22;
		write_reg(CFG_PROTOCOL_SELECT, 16'($urandom_range(1)));
		kind = $urandom_range(3);
		case (kind)
			END_SMALL_LIMIT: begin
				write_reg(CFG_MAX_FRAME_TOTAL, 16'($urandom_range(5, 2)));
				send_frame(FB_BINARY, FORM_SHORT, 64'd1, 1'b1, $urandom, FILL_RANDOM);
			end
			END_CLOSE: begin
				write_reg(CFG_MAX_FRAME_TOTAL, MAX_FRAME_RESET);
				send_frame(CLOSE_BYTE, FORM_SHORT, 64'($urandom_range(5)), 1'b1, $urandom,
					FILL_RANDOM);
			end
			END_HIGH_LENGTH: begin
				send_frame(FB_TEXT, FORM_EXT64,
					{32'h1 << $urandom_range(31), 32'($urandom_range(20))},
					1'b1, $urandom, FILL_RANDOM);
			end
			default: begin
				lim = $urandom_range(131, 7);
				write_reg(CFG_MAX_FRAME_TOTAL, 16'(lim));
				send_frame(FB_TEXT, FORM_SHORT, 64'(lim - 6), 1'b1, $urandom, FILL_RANDOM);
			end
		endcase
		repeat (8) send_byte(8'($urandom));

		settle();
		repeat (16) @(negedge clk);

		$display("Covered %0d stream bytes over %0d idle/stall phases with %0d register writes.",
			frames.bytes_in, PHASE_COUNT, cfg_writes);
		$display("Words: %0d payload, %0d empty, %0d close, %0d length error; ended on %s.",
			frames.event_count[EV_DATA], frames.event_count[EV_EMPTY],
			frames.event_count[EV_CLOSE], frames.event_count[EV_ERROR], end_name[kind]);
		if (frames.errors == 0)
			$display("PASS websocket_frame_deframer");
		else
			$display("FAIL websocket_frame_deframer");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/wsd_out_buf.sv
rtl/websocket_frame_deframer.sv
test/tb_websocket_frame_deframer.sv
